[hw/rtl/dla_pkg.sv]
package dla_pkg;

    localparam int DLA_NUM_DOMAINS = 5;

    typedef enum logic [2:0] {
        ST_GRANT    = 3'd0,
        ST_REFRESH  = 3'd1,
        ST_PREEMPT  = 3'd2,
        ST_INVALID  = 3'd3,
        ST_LOW_PRIO = 3'd4,
        ST_FORBID   = 3'd5,
        ST_RELEASED = 3'd6,
        ST_REFUSED  = 3'd7
    } status_t;

    localparam logic       REQ_PROPOSE = 1'b0;
    localparam logic       REQ_RELEASE = 1'b1;

    localparam logic [1:0] POL_NEVER  = 2'd0;
    localparam logic [1:0] POL_HIGHER = 2'd1;
    localparam logic [1:0] POL_ALWAYS = 2'd2;

    typedef struct packed {
        logic        req_type;
        logic [2:0]  domain;
        logic        proposal_valid;
        logic [15:0] requester;
        logic [7:0]  req_priority;
        logic [31:0] trace_tag;
        logic [31:0] ttl_ms;
        logic [1:0]  preempt_policy;
        logic [63:0] now_ms;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] trace_echo;
        logic [2:0]  domain_echo;
        logic [15:0] owner_out;
        logic [15:0] prior_owner;
        logic        lease_active_out;
        logic [7:0]  lease_priority_out;
        logic [63:0] lease_expiry_out;
        logic [31:0] allowed_total;
        logic [31:0] rejected_total;
        logic [31:0] preempted_total;
    } rslt_t;

endpackage

[hw/rtl/dla_lease_core.sv]
module dla_lease_core #(
    parameter int NUM_DOMAINS = dla_pkg::DLA_NUM_DOMAINS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          req_fire,
    input  dla_pkg::req_t req,
    output dla_pkg::rslt_t rslt
);
    import dla_pkg::*;

    localparam int IDX_W = (NUM_DOMAINS > 1) ? $clog2(NUM_DOMAINS) : 1;

    logic        active_reg   [NUM_DOMAINS];
    logic [15:0] owner_reg    [NUM_DOMAINS];
    logic [7:0]  priority_reg [NUM_DOMAINS];
    logic [63:0] expiry_reg   [NUM_DOMAINS];
    logic [31:0] allow_reg;
    logic [31:0] reject_reg;
    logic [31:0] preempt_reg;

    logic [IDX_W-1:0] idx;
    logic        cur_active;
    logic [15:0] cur_owner;
    logic [7:0]  cur_prio;
    logic [63:0] cur_expiry;
    logic        expired;
    logic        eff_active;
    logic [15:0] eff_owner;
    logic [7:0]  eff_prio;
    logic [63:0] new_expiry;
    logic        higher;
    logic        may_bump;

    logic        ent_active_next;
    logic [15:0] ent_owner_next;
    logic [7:0]  ent_prio_next;
    logic [63:0] ent_expiry_next;
    logic [31:0] allow_next;
    logic [31:0] reject_next;
    logic [31:0] preempt_next;
    status_t     status;
    logic [15:0] prior_owner;

    assign idx = (32'(req.domain) < NUM_DOMAINS) ? IDX_W'(req.domain) : '0;

    assign cur_active = active_reg[idx];
    assign cur_owner  = owner_reg[idx];
    assign cur_prio   = priority_reg[idx];
    assign cur_expiry = expiry_reg[idx];

    // drop a lease whose expiry has been reached before deciding
    assign expired    = cur_active && (req.now_ms >= cur_expiry);
    assign eff_active = cur_active && !expired;
    assign eff_owner  = expired ? 16'd0 : cur_owner;
    assign eff_prio   = expired ? 8'd0 : cur_prio;
    assign new_expiry = req.now_ms + {32'd0, req.ttl_ms};
    assign higher     = req.req_priority > eff_prio;

    always_comb begin
        case (req.preempt_policy)
            POL_ALWAYS: may_bump = 1'b1;
            POL_HIGHER: may_bump = higher;
            default:    may_bump = 1'b0;
        endcase
    end

    always_comb begin
        ent_active_next = cur_active;
        ent_owner_next  = cur_owner;
        ent_prio_next   = cur_prio;
        ent_expiry_next = cur_expiry;
        allow_next      = allow_reg;
        reject_next     = reject_reg;
        preempt_next    = preempt_reg;
        prior_owner     = 16'd0;
        status          = ST_REFUSED;
        if (req.req_type == REQ_RELEASE) begin
            if (cur_active && (cur_owner == req.requester)) begin
                ent_active_next = 1'b0;
                ent_owner_next  = 16'd0;
                ent_prio_next   = 8'd0;
                ent_expiry_next = 64'd0;
                status          = ST_RELEASED;
            end else begin
                status = ST_REFUSED;
            end
        end else if (!req.proposal_valid) begin
            reject_next = reject_reg + 32'd1;
            status      = ST_INVALID;
        end else if (!eff_active || (eff_owner == req.requester) || may_bump) begin
            ent_active_next = 1'b1;
            ent_owner_next  = req.requester;
            ent_prio_next   = req.req_priority;
            ent_expiry_next = new_expiry;
            if (!eff_active) begin
                allow_next = allow_reg + 32'd1;
                status     = ST_GRANT;
            end else if (eff_owner == req.requester) begin
                allow_next = allow_reg + 32'd1;
                status     = ST_REFRESH;
            end else begin
                prior_owner  = eff_owner;
                preempt_next = preempt_reg + 32'd1;
                status       = ST_PREEMPT;
            end
        end else begin
            reject_next = reject_reg + 32'd1;
            status      = higher ? ST_FORBID : ST_LOW_PRIO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_DOMAINS; i++) begin
                active_reg[i]   <= 1'b0;
                owner_reg[i]    <= 16'd0;
                priority_reg[i] <= 8'd0;
                expiry_reg[i]   <= 64'd0;
            end
            allow_reg   <= 32'd0;
            reject_reg  <= 32'd0;
            preempt_reg <= 32'd0;
        end else if (req_fire) begin
            active_reg[idx]   <= ent_active_next;
            owner_reg[idx]    <= ent_owner_next;
            priority_reg[idx] <= ent_prio_next;
            expiry_reg[idx]   <= ent_expiry_next;
            allow_reg         <= allow_next;
            reject_reg        <= reject_next;
            preempt_reg       <= preempt_next;
        end
    end

    always_comb begin
        rslt.status             = status;
        rslt.trace_echo         = req.trace_tag;
        rslt.domain_echo        = req.domain;
        rslt.owner_out          = req.requester;
        rslt.prior_owner        = prior_owner;
        rslt.lease_active_out   = ent_active_next;
        rslt.lease_priority_out = ent_prio_next;
        rslt.lease_expiry_out   = ent_expiry_next;
        rslt.allowed_total      = allow_next;
        rslt.rejected_total     = reject_next;
        rslt.preempted_total    = preempt_next;
    end

endmodule

[hw/rtl/domain_lease_arbiter_top.sv]
// Path: the input register holds a request, then one decision pass loads the
//   result register. Throughput: 1 request per cycle unless m_ready stalls;
//   the lease table and counters update in the same pass that loads the
//   result, so the next request sees them at once.
// Reset: synchronous active-low aresetn clears all leases, counters and valids.
module domain_lease_arbiter_top #(
    parameter int NUM_DOMAINS = dla_pkg::DLA_NUM_DOMAINS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [2:0]  s_domain,
    input  logic        s_proposal_valid,
    input  logic [15:0] s_requester,
    input  logic [7:0]  s_req_priority,
    input  logic [31:0] s_trace_tag,
    input  logic [31:0] s_ttl_ms,
    input  logic [1:0]  s_preempt_policy,
    input  logic [63:0] s_now_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_trace_echo,
    output logic [2:0]  m_domain_echo,
    output logic [15:0] m_owner_out,
    output logic [15:0] m_prior_owner,
    output logic        m_lease_active_out,
    output logic [7:0]  m_lease_priority_out,
    output logic [63:0] m_lease_expiry_out,
    output logic [31:0] m_allowed_total,
    output logic [31:0] m_rejected_total,
    output logic [31:0] m_preempted_total
);
    import dla_pkg::*;

    req_t  req_reg;
    logic  in_valid_reg;
    rslt_t rslt_reg;
    logic  out_valid_reg;
    rslt_t rslt_next;
    logic  advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    dla_lease_core #(
        .NUM_DOMAINS(NUM_DOMAINS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_fire(advance),
        .req     (req_reg),
        .rslt    (rslt_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the request until the decision pass takes it
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg.req_type       <= s_req_type;
            req_reg.domain         <= s_domain;
            req_reg.proposal_valid <= s_proposal_valid;
            req_reg.requester      <= s_requester;
            req_reg.req_priority   <= s_req_priority;
            req_reg.trace_tag      <= s_trace_tag;
            req_reg.ttl_ms         <= s_ttl_ms;
            req_reg.preempt_policy <= s_preempt_policy;
            req_reg.now_ms         <= s_now_ms;
        end
        if (advance) begin
            rslt_reg <= rslt_next;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_status             = rslt_reg.status;
    assign m_trace_echo         = rslt_reg.trace_echo;
    assign m_domain_echo        = rslt_reg.domain_echo;
    assign m_owner_out          = rslt_reg.owner_out;
    assign m_prior_owner        = rslt_reg.prior_owner;
    assign m_lease_active_out   = rslt_reg.lease_active_out;
    assign m_lease_priority_out = rslt_reg.lease_priority_out;
    assign m_lease_expiry_out   = rslt_reg.lease_expiry_out;
    assign m_allowed_total      = rslt_reg.allowed_total;
    assign m_rejected_total     = rslt_reg.rejected_total;
    assign m_preempted_total    = rslt_reg.preempted_total;

endmodule
